FILE: hdl/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
package mpct_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int BYTE_BITS      = 8;
   localparam int SIZE_BITS      = 13;
   localparam int SPEED_BITS     = 8;
   localparam int BTN_BITS       = 3;
   localparam int CSR_IDX_BITS   = 2;

   localparam logic [SIZE_BITS-1:0]  WIDTH_RST  = 13'd1024;
   localparam logic [SIZE_BITS-1:0]  HEIGHT_RST = 13'd768;
   localparam logic [SPEED_BITS-1:0] SPEED_RST  = 8'd6;

   // Button bit positions in the status byte
   localparam int BTN_LEFT   = 0;
   localparam int BTN_RIGHT  = 1;
   localparam int BTN_MIDDLE = 2;

   // Divide by ten: floor(m * RECIP_MUL / 2^RECIP_SHIFT) is exact for any 16-bit m
   localparam int RECIP_MUL   = 52429;
   localparam int RECIP_SHIFT = 19;
   localparam int MAG_BITS    = 16;
   localparam int PROD_BITS   = 17;
   localparam int QUOT_BITS   = 12;
   localparam int MAX_QUOT    = (128 * 255) / 10;

   localparam int MID_DEPTH = 2;
   localparam int OUT_DEPTH = 4;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_SPEED  = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      PH_STATUS = 2'd0,
      PH_X      = 2'd1,
      PH_Y      = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BTN_BITS-1:0]  buttons;
      logic [BYTE_BITS-1:0] dx;
      logic [BYTE_BITS-1:0] dy;
   } pkt_type;

   typedef struct packed {
      logic    push;
      pkt_type pkt;
   } pkt_wr_type;

endpackage

FILE: hdl/mpct_fifo.sv
// Small register-based queue used between the front, back and result side.
module mpct_fifo
   import mpct_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wdata,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rdata,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: hdl/mpct_front.sv
// Byte sequencer: tracks the packet phase and assembles complete packets.
module mpct_front
   import mpct_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [BYTE_BITS-1:0] req_packet_byte,
   output logic                 req_full,
   input  logic                 mid_full,
   output pkt_wr_type           mid_wr
);

   phase_type            phase_ff, phase_in;
   logic [BTN_BITS-1:0]  status_ff, status_in;
   logic [BYTE_BITS-1:0] dx_ff, dx_in;
   logic                 accept;
   logic                 take_status;
   logic                 take_x;
   logic                 last_byte;

   assign accept = req_push && !req_full;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_STATUS: phase_in = PH_X;
            PH_X:      phase_in = PH_Y;
            PH_Y:      phase_in = PH_STATUS;
            default:   phase_in = PH_X;
         endcase
      end
   end

   // Outputs
   always_comb begin
      take_status = 1'b0;
      take_x      = 1'b0;
      last_byte   = 1'b0;
      unique case (phase_ff)
         PH_STATUS: take_status = 1'b1;
         PH_X:      take_x      = 1'b1;
         PH_Y:      last_byte   = 1'b1;
         default:   take_status = 1'b1;
      endcase
   end

   // Only the closing byte needs room in the packet queue
   assign req_full = last_byte && mid_full;

   always_comb begin
      status_in = status_ff;
      dx_in     = dx_ff;
      if (accept && take_status) begin
         status_in = req_packet_byte[BTN_BITS-1:0];
      end
      if (accept && take_x) begin
         dx_in = req_packet_byte;
      end
   end

   assign mid_wr.push        = accept && last_byte;
   assign mid_wr.pkt.buttons = status_ff;
   assign mid_wr.pkt.dx      = dx_ff;
   assign mid_wr.pkt.dy      = req_packet_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_STATUS;
         status_ff <= '0;
         dx_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         dx_ff     <= dx_in;
      end
   end

endmodule

FILE: hdl/mpct_back.sv
// Motion pipeline: scale, divide by ten, update and clamp the cursor position.
module mpct_back
   import mpct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int RES_W      = BTN_BITS + 2 * COORD_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           mid_empty,
   input  pkt_type                        mid_pkt,
   output logic                           mid_pop,
   input  logic [SPEED_BITS-1:0]          speed,
   input  logic [COORD_BITS:0]            eff_width,
   input  logic [COORD_BITS:0]            eff_height,
   input  logic                           recentre,
   input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
   output logic                           out_push,
   output logic [RES_W-1:0]               out_data
);

   localparam int WIDE_BITS = (COORD_BITS > QUOT_BITS) ? COORD_BITS : QUOT_BITS;
   localparam int SUM_W     = WIDE_BITS + 2;
   localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

   function automatic logic [COORD_BITS-1:0] clamp_axis(
      input logic signed [SUM_W-1:0] v,
      input logic [COORD_BITS:0]     lim
   );
      logic [COORD_BITS:0] top;
      top = lim - 1'b1;
      if (v[SUM_W-1]) begin
         return '0;
      end else if ($unsigned(v) >= SUM_W'(lim)) begin
         return top[COORD_BITS-1:0];
      end else begin
         return v[COORD_BITS-1:0];
      end
   endfunction

   // Stage A: products
   logic                        va_ff;
   logic [BTN_BITS-1:0]         btn_a_ff;
   logic signed [PROD_BITS-1:0] prod_x_ff, prod_y_ff;
   logic signed [PROD_BITS-1:0] prod_x_in, prod_y_in;
   // Stage B: magnitudes divided by ten
   logic                        vb_ff;
   logic [BTN_BITS-1:0]         btn_b_ff;
   logic [QUOT_BITS-1:0]        qx_ff, qy_ff;
   logic                        sx_ff, sy_ff;
   logic signed [PROD_BITS-1:0] neg_x, neg_y;
   logic [MAG_BITS-1:0]         mag_x, mag_y;
   logic [2*MAG_BITS-1:0]       rx, ry;
   // Position
   logic [COORD_BITS-1:0]       x_pos_ff, x_pos_in;
   logic [COORD_BITS-1:0]       y_pos_ff, y_pos_in;
   logic [SUM_W-1:0]            x_ext, y_ext, qx_ext, qy_ext;
   logic signed [SUM_W-1:0]     nx, ny;
   logic [CNT_W:0]              pending;

   // Issue only when the result queue has room for everything in flight
   assign pending = (CNT_W + 1)'(out_count) + (CNT_W + 1)'(va_ff) + (CNT_W + 1)'(vb_ff);
   assign mid_pop = !mid_empty && (pending < (CNT_W + 1)'(OUT_DEPTH));

   assign prod_x_in = $signed(mid_pkt.dx) * $signed({1'b0, speed});
   assign prod_y_in = $signed(mid_pkt.dy) * $signed({1'b0, speed});

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= mid_pop;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      btn_a_ff  <= mid_pkt.buttons;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
   end

   assign neg_x = -prod_x_ff;
   assign neg_y = -prod_y_ff;
   assign mag_x = prod_x_ff[PROD_BITS-1] ? neg_x[MAG_BITS-1:0] : prod_x_ff[MAG_BITS-1:0];
   assign mag_y = prod_y_ff[PROD_BITS-1] ? neg_y[MAG_BITS-1:0] : prod_y_ff[MAG_BITS-1:0];
   assign rx    = mag_x * MAG_BITS'(RECIP_MUL);
   assign ry    = mag_y * MAG_BITS'(RECIP_MUL);

   always_ff @(posedge clock) begin
      btn_b_ff <= btn_a_ff;
      qx_ff    <= rx[RECIP_SHIFT+QUOT_BITS-1:RECIP_SHIFT];
      qy_ff    <= ry[RECIP_SHIFT+QUOT_BITS-1:RECIP_SHIFT];
      sx_ff    <= prod_x_ff[PROD_BITS-1];
      sy_ff    <= prod_y_ff[PROD_BITS-1];
   end

   // Stage C: X adds the delta, Y subtracts it
   assign x_ext  = SUM_W'(x_pos_ff);
   assign y_ext  = SUM_W'(y_pos_ff);
   assign qx_ext = SUM_W'(qx_ff);
   assign qy_ext = SUM_W'(qy_ff);
   assign nx     = sx_ff ? x_ext - qx_ext : x_ext + qx_ext;
   assign ny     = sy_ff ? y_ext + qy_ext : y_ext - qy_ext;

   always_comb begin
      x_pos_in = x_pos_ff;
      y_pos_in = y_pos_ff;
      if (recentre) begin
         x_pos_in = eff_width[COORD_BITS:1];
         y_pos_in = eff_height[COORD_BITS:1];
      end else if (vb_ff) begin
         x_pos_in = clamp_axis(nx, eff_width);
         y_pos_in = clamp_axis(ny, eff_height);
      end
   end

   always_ff @(posedge clock) begin
      x_pos_ff <= x_pos_in;
      y_pos_ff <= y_pos_in;
   end

   assign out_push = vb_ff;
   assign out_data = {btn_b_ff, clamp_axis(nx, eff_width), clamp_axis(ny, eff_height)};

   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      va_ff |=> vb_ff)
      else $error("motion pipeline dropped a transaction");

   a_credit: assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> (out_count < CNT_W'(OUT_DEPTH)))
      else $error("result written with no room in the result queue");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      vb_ff |-> (qx_ff <= QUOT_BITS'(MAX_QUOT) && qy_ff <= QUOT_BITS'(MAX_QUOT)))
      else $error("scaled motion out of range");

   a_no_recentre_busy: assert property (@(posedge clock) disable iff (reset)
      recentre |-> !vb_ff)
      else $error("recentre while a packet is in flight");

endmodule

FILE: hdl/mouse_packet_cursor_tracker.sv
// Top level of the mouse packet cursor tracker.
// Takes one mouse byte per cycle through a push/full queue port. Three bytes
// (status, X motion, Y motion) make a packet; after the third byte the block
// produces one result with the button bits and the new cursor position, which
// waits in a four-entry result queue until popped. A finished packet passes a
// two-entry packet queue and a three-register motion pipeline (gain multiply,
// divide by ten, position update and clamp) on its way to the result ports.
// The byte port stalls only when the third byte finds the packet queue full,
// which happens only while the result queue is backed up. Writing a screen
// size registers a recentre request that moves the cursor to the centre of
// the screen; reset does the same.
module mouse_packet_cursor_tracker
   import mpct_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [BYTE_BITS-1:0]    req_packet_byte,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic                    rsp_left_pressed,
   output logic                    rsp_right_pressed,
   output logic                    rsp_middle_pressed,
   output logic [COORD_BITS-1:0]   rsp_cursor_x,
   output logic [COORD_BITS-1:0]   rsp_cursor_y,
   input  logic                    csr_write,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [SIZE_BITS-1:0]    csr_wdata
);

   localparam int SZ_W    = (COORD_BITS + 1 > SIZE_BITS) ? COORD_BITS + 1 : SIZE_BITS;
   localparam int RES_W   = BTN_BITS + 2 * COORD_BITS;
   localparam int PKT_W   = $bits(pkt_type);
   localparam int OCNT_W  = $clog2(OUT_DEPTH + 1);
   localparam int MCNT_W  = $clog2(MID_DEPTH + 1);
   localparam logic [SZ_W-1:0] TOP_SIZE = {{(SZ_W-1){1'b0}}, 1'b1} << COORD_BITS;

   function automatic logic [COORD_BITS:0] eff_size(input logic [SIZE_BITS-1:0] size);
      logic [SZ_W-1:0] ext;
      ext = SZ_W'(size);
      if (ext == '0) begin
         return (COORD_BITS + 1)'(1);
      end else if (ext > TOP_SIZE) begin
         return TOP_SIZE[COORD_BITS:0];
      end else begin
         return ext[COORD_BITS:0];
      end
   endfunction

   csr_idx_type             csr_sel;
   logic [COORD_BITS:0]     eff_width_ff, eff_width_in;
   logic [COORD_BITS:0]     eff_height_ff, eff_height_in;
   logic [SPEED_BITS-1:0]   speed_ff, speed_in;
   logic                    recentre_ff, recentre_in;

   pkt_wr_type              mid_wr;
   logic [PKT_W-1:0]        mid_rdata;
   logic                    mid_full, mid_empty, mid_pop;
   logic [MCNT_W-1:0]       mid_count;
   pkt_type                 mid_pkt;

   logic                    out_push;
   logic [RES_W-1:0]        out_wdata, out_rdata;
   logic                    out_full;
   logic [OCNT_W-1:0]       out_count;

   assign csr_sel = csr_idx_type'(csr_index);

   always_comb begin
      eff_width_in  = eff_width_ff;
      eff_height_in = eff_height_ff;
      speed_in      = speed_ff;
      recentre_in   = 1'b0;
      if (csr_write) begin
         unique case (csr_sel)
            CSR_WIDTH: begin
               eff_width_in = eff_size(csr_wdata);
               recentre_in  = 1'b1;
            end
            CSR_HEIGHT: begin
               eff_height_in = eff_size(csr_wdata);
               recentre_in   = 1'b1;
            end
            CSR_SPEED: speed_in = csr_wdata[SPEED_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_width_ff  <= eff_size(WIDTH_RST);
         eff_height_ff <= eff_size(HEIGHT_RST);
         speed_ff      <= SPEED_RST;
         recentre_ff   <= 1'b1;
      end else begin
         eff_width_ff  <= eff_width_in;
         eff_height_ff <= eff_height_in;
         speed_ff      <= speed_in;
         recentre_ff   <= recentre_in;
      end
   end

   mpct_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_packet_byte (req_packet_byte),
      .req_full        (req_full),
      .mid_full        (mid_full),
      .mid_wr          (mid_wr)
   );

   mpct_fifo #(
      .WIDTH (PKT_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (mid_wr.push),
      .wdata (mid_wr.pkt),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .full  (mid_full),
      .empty (mid_empty),
      .count (mid_count)
   );

   assign mid_pkt = pkt_type'(mid_rdata);

   mpct_back #(
      .COORD_BITS (COORD_BITS),
      .RES_W      (RES_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .mid_empty  (mid_empty),
      .mid_pkt    (mid_pkt),
      .mid_pop    (mid_pop),
      .speed      (speed_ff),
      .eff_width  (eff_width_ff),
      .eff_height (eff_height_ff),
      .recentre   (recentre_ff),
      .out_count  (out_count),
      .out_push   (out_push),
      .out_data   (out_wdata)
   );

   mpct_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (out_wdata),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .full  (out_full),
      .empty (rsp_empty),
      .count (out_count)
   );

   assign rsp_left_pressed   = out_rdata[2*COORD_BITS + BTN_LEFT];
   assign rsp_right_pressed  = out_rdata[2*COORD_BITS + BTN_RIGHT];
   assign rsp_middle_pressed = out_rdata[2*COORD_BITS + BTN_MIDDLE];
   assign rsp_cursor_x       = out_rdata[2*COORD_BITS-1:COORD_BITS];
   assign rsp_cursor_y       = out_rdata[COORD_BITS-1:0];

   a_mid_bound: assert property (@(posedge clock) disable iff (reset)
      mid_count <= MCNT_W'(MID_DEPTH))
      else $error("packet queue count out of range");

   a_out_no_overflow: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full)
      else $error("result transaction pushed into a full queue");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_full |-> mid_full)
      else $error("byte port stalled with room in the packet queue");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the mouse packet cursor tracker.
`timescale 1ns / 100ps

module tb_top;
   import mpct_pkg::*;

   localparam int COORD_BITS       = COORD_BITS_DEF;
   localparam int COORD_SPAN       = 1 << COORD_BITS;
   localparam int GAIN_DIV         = 10;
   localparam int DRAIN_CYCLES     = 8;
   localparam int RAND_PHASES      = 6;
   localparam int PHASE_BYTES      = 65;
   localparam int HOLD_AFTER_POPS  = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int REPORT_LIMIT     = 10;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                  left;
      logic                  right;
      logic                  middle;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } cursor_type;

   typedef struct packed {
      logic                    is_reg;
      logic [CSR_IDX_BITS-1:0] reg_idx;
      logic [SIZE_BITS-1:0]    value;
      logic                    typed;
      cursor_type              want;
   } drill_row_type;

   logic                    clock;
   logic                    reset           = 1'b1;
   logic                    req_push        = 1'b0;
   logic                    req_full;
   logic [BYTE_BITS-1:0]    req_packet_byte = '0;
   logic                    rsp_empty;
   logic                    rsp_pop         = 1'b0;
   logic                    rsp_left_pressed;
   logic                    rsp_right_pressed;
   logic                    rsp_middle_pressed;
   logic [COORD_BITS-1:0]   rsp_cursor_x;
   logic [COORD_BITS-1:0]   rsp_cursor_y;
   logic                    csr_write       = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index       = '0;
   logic [SIZE_BITS-1:0]    csr_wdata       = '0;

   // Tracker state as the block should hold it
   logic [SIZE_BITS-1:0]  trk_width;
   logic [SIZE_BITS-1:0]  trk_height;
   logic [SPEED_BITS-1:0] trk_speed;
   phase_type             trk_phase;
   logic [BYTE_BITS-1:0]  trk_status;
   logic [BYTE_BITS-1:0]  trk_dx;
   logic [COORD_BITS-1:0] trk_x;
   logic [COORD_BITS-1:0] trk_y;

   cursor_type    pending_cursor_q[$];
   drill_row_type drills[$];
   int            fault_count = 0;
   int            pops_seen   = 0;
   int            cycle_count = 0;
   bit            rx_holding  = 1'b0;
   bit            hold_done   = 1'b0;

   mouse_packet_cursor_tracker #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_packet_byte    (req_packet_byte),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_left_pressed   (rsp_left_pressed),
      .rsp_right_pressed  (rsp_right_pressed),
      .rsp_middle_pressed (rsp_middle_pressed),
      .rsp_cursor_x       (rsp_cursor_x),
      .rsp_cursor_y       (rsp_cursor_y),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int axis_span(logic [SIZE_BITS-1:0] size);
      if (size == 0) return 1;
      if (size > COORD_SPAN) return COORD_SPAN;
      return int'(size);
   endfunction

   // Signed delta times gain in tenths; int division truncates toward zero
   function automatic int gain_scale(logic [BYTE_BITS-1:0] raw);
      int d;
      int p;
      d = $signed(raw);
      p = d * int'(trk_speed);
      return p / GAIN_DIV;
   endfunction

   function automatic logic [COORD_BITS-1:0] clamp_to_span(int v, int span);
      if (v < 0) return '0;
      if (v >= span) return COORD_BITS'(span - 1);
      return COORD_BITS'(v);
   endfunction

   function automatic void recentre_cursor();
      trk_x = COORD_BITS'(axis_span(trk_width) >> 1);
      trk_y = COORD_BITS'(axis_span(trk_height) >> 1);
   endfunction

   function automatic void track_byte(input logic [BYTE_BITS-1:0] b, output bit done,
                                      output cursor_type res);
      int nx;
      int ny;
      done = 1'b0;
      res  = '0;
      case (trk_phase)
         PH_X: begin
            trk_dx    = b;
            trk_phase = PH_Y;
         end
         PH_Y: begin
            nx         = int'(trk_x) + gain_scale(trk_dx);
            ny         = int'(trk_y) - gain_scale(b);
            trk_x      = clamp_to_span(nx, axis_span(trk_width));
            trk_y      = clamp_to_span(ny, axis_span(trk_height));
            trk_phase  = PH_STATUS;
            res.left   = trk_status[BTN_LEFT];
            res.right  = trk_status[BTN_RIGHT];
            res.middle = trk_status[BTN_MIDDLE];
            res.x      = trk_x;
            res.y      = trk_y;
            done       = 1'b1;
         end
         default: begin
            trk_status = b;
            trk_phase  = PH_X;
         end
      endcase
   endfunction

   function automatic drill_row_type byte_row(logic [BYTE_BITS-1:0] b);
      drill_row_type r;
      r       = '0;
      r.value = SIZE_BITS'(b);
      return r;
   endfunction

   function automatic drill_row_type end_row(logic [BYTE_BITS-1:0] b, logic l, logic r_btn,
                                             logic m, int x, int y);
      drill_row_type r;
      r       = byte_row(b);
      r.typed = 1'b1;
      r.want  = {l, r_btn, m, COORD_BITS'(x), COORD_BITS'(y)};
      return r;
   endfunction

   function automatic drill_row_type reg_row(logic [CSR_IDX_BITS-1:0] idx,
                                             logic [SIZE_BITS-1:0] v);
      drill_row_type r;
      r         = '0;
      r.is_reg  = 1'b1;
      r.reg_idx = idx;
      r.value   = v;
      return r;
   endfunction

   function automatic logic [SIZE_BITS-1:0] pick_size();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return SIZE_BITS'(1);
         2: return SIZE_BITS'(COORD_SPAN);
         3: return '1;
         4: return SIZE_BITS'($urandom_range(COORD_SPAN + 1, (1 << SIZE_BITS) - 2));
         default: return SIZE_BITS'($urandom_range(2, COORD_SPAN - 1));
      endcase
   endfunction

   task automatic send_byte(input logic [BYTE_BITS-1:0] b, input logic typed,
                            input cursor_type want);
      cursor_type predicted;
      bit         done;
      req_push        <= 1'b1;
      req_packet_byte <= b;
      do @(posedge clock); while (req_full);
      track_byte(b, done, predicted);
      if (done) pending_cursor_q.push_back(typed ? want : predicted);
   endtask

   // Keep push high for back-to-back bytes, or drop it for a random gap
   task automatic sender_pause();
      int pick;
      pick = $urandom_range(0, 99);
      if (rx_holding || pick < 55) return;
      req_push <= 1'b0;
      if (pick < 90) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(10, 40)) @(posedge clock);
   endtask

   task automatic settle_block();
      req_push <= 1'b0;
      while (pending_cursor_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [SIZE_BITS-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_WIDTH: begin
            trk_width = val;
            recentre_cursor();
         end
         CSR_HEIGHT: begin
            trk_height = val;
            recentre_cursor();
         end
         CSR_SPEED: trk_speed = val[SPEED_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Stimulus: directed packets first, then random phases under fresh settings
   initial begin
      logic [BYTE_BITS-1:0] b;
      int                   ph;
      int                   n;
      trk_width  = WIDTH_RST;
      trk_height = HEIGHT_RST;
      trk_speed  = SPEED_RST;
      trk_phase  = PH_STATUS;
      trk_status = '0;
      trk_dx     = '0;
      recentre_cursor();

      // At reset the cursor sits at the screen centre
      drills.push_back(byte_row(8'h00));
      drills.push_back(byte_row(8'h00));
      drills.push_back(end_row(8'h00, 0, 0, 0, 512, 384));
      // All status bits set, largest deltas at the reset gain
      drills.push_back(byte_row(8'hFF));
      drills.push_back(byte_row(8'h7F));
      drills.push_back(end_row(8'h80, 1, 1, 1, 588, 460));
      // Full gain drives both axes into the low clamp, then the high clamp
      drills.push_back(reg_row(CSR_SPEED, 13'd255));
      drills.push_back(byte_row(8'h01));
      drills.push_back(byte_row(8'h80));
      drills.push_back(end_row(8'h7F, 1, 0, 0, 0, 0));
      drills.push_back(byte_row(8'h02));
      drills.push_back(byte_row(8'h7F));
      drills.push_back(end_row(8'h80, 0, 1, 0, 1023, 767));
      // Zero width acts as one, oversize height as the coordinate span
      drills.push_back(reg_row(CSR_WIDTH, 13'd0));
      drills.push_back(reg_row(CSR_HEIGHT, 13'h1FFF));
      drills.push_back(byte_row(8'h04));
      drills.push_back(byte_row(8'h7F));
      drills.push_back(end_row(8'h80, 0, 0, 1, 0, 4095));
      // A write to the unused index changes nothing; zero gain freezes the cursor
      drills.push_back(reg_row(CSR_UNUSED, 13'h1FFF));
      drills.push_back(reg_row(CSR_SPEED, 13'd0));
      drills.push_back(byte_row(8'h03));
      drills.push_back(byte_row(8'h80));
      drills.push_back(end_row(8'h7F, 1, 1, 0, 0, 4095));
      // Small negative products truncate toward zero
      drills.push_back(reg_row(CSR_WIDTH, 13'd4096));
      drills.push_back(reg_row(CSR_SPEED, 13'd15));
      drills.push_back(byte_row(8'hF8));
      drills.push_back(byte_row(8'hFF));
      drills.push_back(byte_row(8'h01));
      drills.push_back(reg_row(CSR_WIDTH, 13'd1024));
      drills.push_back(reg_row(CSR_HEIGHT, 13'd768));
      drills.push_back(reg_row(CSR_SPEED, 13'd6));
      drills.push_back(byte_row(8'h05));
      drills.push_back(byte_row(8'h05));
      drills.push_back(byte_row(8'hF9));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      foreach (drills[i]) begin
         if (drills[i].is_reg) begin
            settle_block();
            write_reg(drills[i].reg_idx, drills[i].value);
         end else begin
            send_byte(drills[i].value[BYTE_BITS-1:0], drills[i].typed, drills[i].want);
            sender_pause();
         end
      end

      for (ph = 0; ph < RAND_PHASES; ph++) begin
         settle_block();
         write_reg(CSR_WIDTH, pick_size());
         write_reg(CSR_HEIGHT, pick_size());
         case ($urandom_range(0, 5))
            0: write_reg(CSR_SPEED, '0);
            1: write_reg(CSR_SPEED, SIZE_BITS'(255));
            default: write_reg(CSR_SPEED, SIZE_BITS'($urandom_range(1, 40)));
         endcase
         if ($urandom_range(0, 2) == 0) write_reg(CSR_UNUSED, SIZE_BITS'($urandom()));
         for (n = 0; n < PHASE_BYTES; n++) begin
            // Motion bytes are small half of the time so the cursor roams
            if (trk_phase != PH_STATUS && $urandom_range(0, 1) == 0)
               b = BYTE_BITS'($urandom_range(0, 30) - 15);
            else
               b = BYTE_BITS'($urandom_range(0, 255));
            send_byte(b, 1'b0, '0);
            sender_pause();
         end
      end

      settle_block();
      if (fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Result side: random pop pattern with one long hold-off to back up the block
   initial begin
      int pick;
      int run;
      repeat (13) @(posedge clock);
      forever begin
         if (!hold_done && pops_seen >= HOLD_AFTER_POPS) begin
            rsp_pop    <= 1'b0;
            rx_holding  = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rx_holding  = 1'b0;
            hold_done   = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               rsp_pop <= 1'b1;
               run = $urandom_range(1, 20);
            end else if (pick < 95) begin
               rsp_pop <= 1'b0;
               run = $urandom_range(1, 4);
            end else begin
               rsp_pop <= 1'b0;
               run = $urandom_range(20, 60);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   // Compare each popped transaction with the oldest expected cursor
   always @(posedge clock) begin
      cursor_type got;
      cursor_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got = {rsp_left_pressed, rsp_right_pressed, rsp_middle_pressed,
                rsp_cursor_x, rsp_cursor_y};
         if (pending_cursor_q.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("unexpected result: l=%0d r=%0d m=%0d x=%0d y=%0d",
                        got.left, got.right, got.middle, got.x, got.y);
         end else begin
            want = pending_cursor_q.pop_front();
            pops_seen++;
            if (got !== want) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("mismatch: expected l=%0d r=%0d m=%0d x=%0d y=%0d,",
                           want.left, want.right, want.middle, want.x, want.y,
                           " got l=%0d r=%0d m=%0d x=%0d y=%0d",
                           got.left, got.right, got.middle, got.x, got.y);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
